// ===== sv/spi_register_access_sequencer_unit_macros.svh =====
// assertion macros for the spi register access sequencer
`ifndef SPI_REGISTER_ACCESS_SEQUENCER_UNIT_MACROS_SVH
`define SPI_REGISTER_ACCESS_SEQUENCER_UNIT_MACROS_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication, sampled on clk, off while rst_n is low
`define SRAS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication, sampled on clk, off while rst_n is low
`define SRAS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define SRAS_ASSERT_NOW(label, ante, cons, msg)
`define SRAS_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

// ===== sv/sras_pkg.sv =====
package sras_pkg;

    localparam int IDX_W = 5;

    localparam logic [1:0] MODE_LOAD     = 2'd0;
    localparam logic [1:0] MODE_START_RD = 2'd1;
    localparam logic [1:0] MODE_START_WR = 2'd2;
    localparam logic [1:0] MODE_BYTE_DONE = 2'd3;

    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_ADDR = 2'd1;
    localparam logic [1:0] PH_TX   = 2'd2;
    localparam logic [1:0] PH_RX   = 2'd3;

    localparam logic [7:0] WRITE_FLAG = 8'h80;
    localparam logic [7:0] DUMMY_BYTE = 8'hFF;

    typedef struct packed {
        logic [1:0]       mode;
        logic [6:0]       slave_addr;
        logic [5:0]       count;
        logic [IDX_W-1:0] buf_index;
        logic [7:0]       write_byte;
        logic [7:0]       rx_byte;
    } item_t;

    typedef struct packed {
        logic             send_valid;
        logic [7:0]       send_byte;
        logic             select_active;
        logic             capture_valid;
        logic [IDX_W-1:0] capture_index;
        logic [7:0]       capture_byte;
        logic             done_res;
        logic [1:0]       phase;
    } res_t;

    typedef struct packed {
        logic [1:0] phase;
        logic       tx_pending;
        logic       rx_pending;
    } stat_t;

endpackage

// ===== sv/sras_store.sv =====
module sras_store import sras_pkg::*; #(
    parameter int BUFFER_DEPTH = 32,
    parameter int AW = 5
) (
    input  logic          clk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [7:0]    wr_data,
    input  logic [AW-1:0] rd_addr,
    output logic [7:0]    rd_data
);

    logic [7:0] mem [BUFFER_DEPTH];
    logic [7:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // write-first: a load landing on the slot being fetched wins
    always_ff @(posedge clk)
    begin
        if (wr_en && (wr_addr == rd_addr))
        begin
            rd_data_reg <= wr_data;
        end
        else
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== sv/sras_seq.sv =====
module sras_seq import sras_pkg::*; #(
    parameter int BUFFER_DEPTH = 32,
    parameter int AW = 5
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          adv,
    input  item_t         item,
    input  logic [7:0]    rd_data,
    output res_t          res,
    output logic          wr_en,
    output logic [AW-1:0] wr_addr,
    output logic [AW-1:0] rd_addr,
    output stat_t         status
);

    localparam int CNT_W = $clog2(BUFFER_DEPTH + 1);
    localparam int CMP_W = (CNT_W > 6) ? CNT_W : 6;
    localparam int SLOTS = 2 ** IDX_W;

    logic [1:0]       phase_reg, phase_next;
    logic [CNT_W-1:0] tx_rem_reg, tx_rem_next;
    logic [CNT_W-1:0] rx_rem_reg, rx_rem_next;
    logic [AW-1:0]    txp_reg, txp_next;
    logic [IDX_W-1:0] rxp_reg, rxp_next;

    logic [AW-1:0]    slot_lut [SLOTS];
    logic [CMP_W-1:0] cnt_ext;
    logic [CMP_W-1:0] cnt_sat;
    logic [CNT_W-1:0] n_bytes;
    logic [AW-1:0]    txp_inc;
    logic [CNT_W-1:0] rx_rem_dec;

    // slot index folded onto the store depth
    for (genvar g = 0; g < SLOTS; g++)
    begin : g_slot
        assign slot_lut[g] = AW'(g % BUFFER_DEPTH);
    end

    assign cnt_ext = CMP_W'(item.count);
    assign cnt_sat = (cnt_ext > CMP_W'(BUFFER_DEPTH)) ? CMP_W'(BUFFER_DEPTH) : cnt_ext;
    assign n_bytes = CNT_W'(cnt_sat);
    assign txp_inc = (txp_reg == AW'(BUFFER_DEPTH - 1)) ? '0 : txp_reg + AW'(1);
    assign rx_rem_dec = rx_rem_reg - CNT_W'(1);

    always_comb
    begin
        phase_next  = phase_reg;
        tx_rem_next = tx_rem_reg;
        rx_rem_next = rx_rem_reg;
        txp_next    = txp_reg;
        rxp_next    = rxp_reg;
        res         = '0;
        case (item.mode)
            MODE_LOAD:
            begin
            end
            MODE_START_RD, MODE_START_WR:
            begin
                if (phase_reg == PH_IDLE)
                begin
                    phase_next     = PH_ADDR;
                    txp_next       = '0;
                    rxp_next       = '0;
                    res.send_valid = 1'b1;
                    if (item.mode == MODE_START_RD)
                    begin
                        rx_rem_next   = n_bytes;
                        tx_rem_next   = '0;
                        res.send_byte = {1'b0, item.slave_addr};
                    end
                    else
                    begin
                        tx_rem_next   = n_bytes;
                        rx_rem_next   = '0;
                        res.send_byte = {1'b0, item.slave_addr} | WRITE_FLAG;
                    end
                end
            end
            default:
            begin
                case (phase_reg)
                    PH_ADDR, PH_TX:
                    begin
                        if ((phase_reg == PH_ADDR) && (rx_rem_reg != '0))
                        begin
                            phase_next     = PH_RX;
                            res.send_valid = 1'b1;
                            res.send_byte  = DUMMY_BYTE;
                        end
                        else if (tx_rem_reg != '0)
                        begin
                            phase_next     = PH_TX;
                            res.send_valid = 1'b1;
                            res.send_byte  = rd_data;
                            txp_next       = txp_inc;
                            tx_rem_next    = tx_rem_reg - CNT_W'(1);
                        end
                        else
                        begin
                            phase_next   = PH_IDLE;
                            res.done_res = 1'b1;
                        end
                    end
                    PH_RX:
                    begin
                        if (rx_rem_reg != '0)
                        begin
                            res.capture_valid = 1'b1;
                            res.capture_index = rxp_reg;
                            res.capture_byte  = item.rx_byte;
                            rxp_next          = rxp_reg + IDX_W'(1);
                            rx_rem_next       = rx_rem_dec;
                        end
                        if ((rx_rem_reg == '0) || (rx_rem_dec == '0))
                        begin
                            phase_next   = PH_IDLE;
                            res.done_res = 1'b1;
                        end
                        else
                        begin
                            res.send_valid = 1'b1;
                            res.send_byte  = DUMMY_BYTE;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
        endcase
        res.phase         = phase_next;
        res.select_active = (phase_next != PH_IDLE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_IDLE;
            tx_rem_reg <= '0;
            rx_rem_reg <= '0;
            txp_reg    <= '0;
            rxp_reg    <= '0;
        end
        else if (adv)
        begin
            phase_reg  <= phase_next;
            tx_rem_reg <= tx_rem_next;
            rx_rem_reg <= rx_rem_next;
            txp_reg    <= txp_next;
            rxp_reg    <= rxp_next;
        end
    end

    // prefetch the slot the pointer will hold after this edge
    assign rd_addr = adv ? txp_next : txp_reg;
    assign wr_en   = adv && (item.mode == MODE_LOAD);
    assign wr_addr = slot_lut[item.buf_index];

    assign status.phase      = phase_reg;
    assign status.tx_pending = (tx_rem_reg != '0);
    assign status.rx_pending = (rx_rem_reg != '0);

endmodule

// ===== sv/spi_register_access_sequencer_unit.sv =====
// spi register access sequencer: master-side byte sequencer for register reads and writes.
// a load transaction (tuser 0) stores write_byte in transmit slot buf_index; a start
// transaction (tuser 1 read, 2 write) opens an access and returns the address byte to shift
// out (address or 0x80 for a write); each byte-done transaction (tuser 3) carries the byte
// shifted in and returns the next byte to send (stored data for a write, 0xff dummies for a
// read), any captured read byte with its index, and tlast on the transaction that closes the
// access. count is saturated to BUFFER_DEPTH, a zero count ends after the address byte,
// starts while busy and byte-done while idle are ignored. every input transaction gives
// exactly one result. throughput is one transaction per clock unless m_tready stalls the
// result stage; the path is an input register, one pass through the phase logic with a
// prefetched transmit store read, and a result register; no store clearing after reset.
`include "spi_register_access_sequencer_unit_macros.svh"

module spi_register_access_sequencer_unit import sras_pkg::*; #(
    parameter int BUFFER_DEPTH = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // from bit 0: slave_addr[6:0], count[5:0], buf_index[4:0], write_byte[7:0],
    // rx_byte[7:0], zero pad
    input  logic [39:0] s_tdata,
    // mode[1:0]
    input  logic [1:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // from bit 0: send_valid, send_byte[7:0], select_active, capture_valid,
    // capture_index[4:0], capture_byte[7:0], phase[1:0], zero pad
    output logic [31:0] m_tdata,
    // done_res
    output logic        m_tlast
);

    localparam int AW = $clog2(BUFFER_DEPTH);

    // input stage
    item_t in_reg;
    logic  in_v_reg;
    // result stage
    res_t  out_reg;
    logic  out_v_reg;

    logic          adv;
    res_t          res;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [AW-1:0] rd_addr;
    logic [7:0]    rd_data;
    stat_t         status;

    // the input stage moves on whenever the result stage is empty or being drained
    assign adv      = in_v_reg && (!out_v_reg || m_tready);
    assign s_tready = !in_v_reg || adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_v_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_v_reg <= s_tvalid;
        end
    end

    // payload capture, no reset needed
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_reg.mode       <= s_tuser;
            in_reg.slave_addr <= s_tdata[6:0];
            in_reg.count      <= s_tdata[12:7];
            in_reg.buf_index  <= s_tdata[17:13];
            in_reg.write_byte <= s_tdata[25:18];
            in_reg.rx_byte    <= s_tdata[33:26];
        end
    end

    // transmit byte store
    sras_store #(
        .BUFFER_DEPTH (BUFFER_DEPTH),
        .AW           (AW)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (in_reg.write_byte),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // phase logic and access state
    sras_seq #(
        .BUFFER_DEPTH (BUFFER_DEPTH),
        .AW           (AW)
    ) u_seq (
        .clk     (clk),
        .rst_n   (rst_n),
        .adv     (adv),
        .item    (in_reg),
        .rd_data (rd_data),
        .res     (res),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .rd_addr (rd_addr),
        .status  (status)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_v_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_v_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_v_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_reg <= res;
        end
    end

    assign m_tvalid = out_v_reg;
    assign m_tlast  = out_reg.done_res;
    assign m_tdata  = {6'b0, out_reg.phase, out_reg.capture_byte, out_reg.capture_index,
                       out_reg.capture_valid, out_reg.select_active, out_reg.send_byte,
                       out_reg.send_valid};

    // an idle sequencer has nothing left to send or receive
    `SRAS_ASSERT_NOW(a_idle_empty, status.phase == PH_IDLE,
        !status.tx_pending && !status.rx_pending, "idle with bytes pending")

    // the closing transaction always reports the idle phase with select released
    `SRAS_ASSERT_NOW(a_done_idle, out_v_reg && out_reg.done_res,
        (out_reg.phase == PH_IDLE) && !out_reg.select_active, "done while still active")

    // a captured read byte lands in the result stage on the next cycle
    `SRAS_ASSERT_NEXT(a_capture_flow, adv && res.capture_valid,
        out_v_reg && out_reg.capture_valid && (status.phase == PH_RX || status.phase == PH_IDLE),
        "capture lost or outside read phase")

endmodule

// ===== tb/tb_spi_register_access_sequencer_unit.sv =====
module tb_spi_register_access_sequencer_unit;

    import sras_pkg::*;

    localparam int BUF_DEPTH   = 32;
    localparam int CYCLE_LIMIT = 300000;

    // clock, reset and the two stream groups
    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    // from bit 0: slave_addr[6:0], count[5:0], buf_index[4:0], write_byte[7:0],
    // rx_byte[7:0], zero pad
    logic [39:0] s_tdata;
    // mode[1:0]
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    // from bit 0: send_valid, send_byte[7:0], select_active, capture_valid,
    // capture_index[4:0], capture_byte[7:0], phase[1:0], zero pad
    logic [31:0] m_tdata;
    // done_res
    logic        m_tlast;

    // shadow of the sequencer state, advanced once per accepted input transaction
    logic [1:0]  seq_phase;
    logic [5:0]  tx_left;
    logic [5:0]  rx_left;
    logic [4:0]  tx_ptr;
    logic [4:0]  rx_ptr;
    logic [7:0]  tx_image [BUF_DEPTH];
    // slots written so far; a write access never reaches past the loaded prefix
    logic [BUF_DEPTH-1:0] slot_loaded;

    // results still owed by the block, oldest first
    res_t        access_results [$];
    res_t        want_res;

    int          items_sent;
    int          mismatches;
    int          cycle_count;

    // idling controls: random bursts on either side, plus one long receiver hold
    bit          src_gaps_on;
    bit          sink_gaps_on;
    int          sink_hold_cycles;
    int          sink_stall_left;

    spi_register_access_sequencer_unit #(
        .BUFFER_DEPTH(BUF_DEPTH)
    ) uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    initial clk = 1'b0;

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // watchdog: a hung handshake ends the run as a failure
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // next transmit byte of a write access; pointer wraps over the store
    function automatic logic [7:0] pop_tx_byte();
        logic [7:0] b;
        b = tx_image[tx_ptr];
        tx_ptr = tx_ptr + 5'd1;
        tx_left = tx_left - 6'd1;
        return b;
    endfunction

    // expected result of one input transaction, updating the shadow state
    function automatic res_t advance_sequencer(input item_t it);
        res_t r;
        logic [5:0] n;
        r = '0;
        case (it.mode)
            MODE_LOAD:
            begin
                tx_image[it.buf_index] = it.write_byte;
            end
            MODE_START_RD, MODE_START_WR:
            begin
                // a start while busy leaves everything as it is
                if (seq_phase == PH_IDLE)
                begin
                    n = (it.count > BUF_DEPTH) ? 6'(BUF_DEPTH) : it.count;
                    seq_phase = PH_ADDR;
                    tx_ptr = '0;
                    rx_ptr = '0;
                    r.send_valid = 1'b1;
                    if (it.mode == MODE_START_RD)
                    begin
                        rx_left = n;
                        tx_left = '0;
                        r.send_byte = {1'b0, it.slave_addr};
                    end
                    else
                    begin
                        tx_left = n;
                        rx_left = '0;
                        r.send_byte = {1'b0, it.slave_addr} | WRITE_FLAG;
                    end
                end
            end
            default:
            begin
                case (seq_phase)
                    PH_ADDR:
                    begin
                        if (rx_left != 0)
                        begin
                            seq_phase = PH_RX;
                            r.send_valid = 1'b1;
                            r.send_byte = DUMMY_BYTE;
                        end
                        else if (tx_left != 0)
                        begin
                            seq_phase = PH_TX;
                            r.send_valid = 1'b1;
                            r.send_byte = pop_tx_byte();
                        end
                        else
                        begin
                            // zero-length access ends right after the address byte
                            seq_phase = PH_IDLE;
                            r.done_res = 1'b1;
                        end
                    end
                    PH_TX:
                    begin
                        if (tx_left != 0)
                        begin
                            r.send_valid = 1'b1;
                            r.send_byte = pop_tx_byte();
                        end
                        else
                        begin
                            seq_phase = PH_IDLE;
                            r.done_res = 1'b1;
                        end
                    end
                    PH_RX:
                    begin
                        if (rx_left != 0)
                        begin
                            r.capture_valid = 1'b1;
                            r.capture_index = rx_ptr;
                            r.capture_byte = it.rx_byte;
                            rx_ptr = rx_ptr + 5'd1;
                            rx_left = rx_left - 6'd1;
                        end
                        if (rx_left == 0)
                        begin
                            seq_phase = PH_IDLE;
                            r.done_res = 1'b1;
                        end
                        else
                        begin
                            r.send_valid = 1'b1;
                            r.send_byte = DUMMY_BYTE;
                        end
                    end
                    default:
                    begin
                        // byte done while idle gives an all-zero result
                    end
                endcase
            end
        endcase
        r.select_active = (seq_phase != PH_IDLE);
        r.phase = seq_phase;
        return r;
    endfunction

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got)
        begin
            $error("%s expected %0h actual %0h", name, want, got);
            mismatches++;
        end
    endtask

    // result checker: every accepted output transaction against the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (access_results.size() == 0)
            begin
                $error("result transaction %h arrived with nothing pending", m_tdata);
                mismatches++;
            end
            else
            begin
                want_res = access_results.pop_front();
                check_field("send_valid", 32'(want_res.send_valid), 32'(m_tdata[0]));
                check_field("send_byte", 32'(want_res.send_byte), 32'(m_tdata[8:1]));
                check_field("select_active", 32'(want_res.select_active),
                            32'(m_tdata[9]));
                check_field("capture_valid", 32'(want_res.capture_valid),
                            32'(m_tdata[10]));
                check_field("capture_index", 32'(want_res.capture_index),
                            32'(m_tdata[15:11]));
                check_field("capture_byte", 32'(want_res.capture_byte),
                            32'(m_tdata[23:16]));
                check_field("phase", 32'(want_res.phase), 32'(m_tdata[25:24]));
                check_field("done_res", 32'(want_res.done_res), 32'(m_tlast));
            end
        end
    end

    // receiver side: random stall bursts, and a long hold counted down here
    initial
    begin
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (sink_hold_cycles > 0)
            begin
                m_tready = 1'b0;
                sink_hold_cycles--;
            end
            else if (sink_stall_left > 0)
            begin
                m_tready = 1'b0;
                sink_stall_left--;
            end
            else if (sink_gaps_on && $urandom_range(0, 9) == 0)
            begin
                m_tready = 1'b0;
                sink_stall_left = $urandom_range(0, 14);
            end
            else
            begin
                m_tready = 1'b1;
            end
        end
    end

    // sender gap: drives tvalid low, starting at the next falling edge
    task automatic source_gap(input int n);
        repeat (n)
        begin
            @(negedge clk);
            s_tvalid = 1'b0;
        end
    endtask

    // drive one input transaction and record its expected result on acceptance
    task automatic send_item(input item_t it);
        if (src_gaps_on && $urandom_range(0, 7) == 0)
            source_gap($urandom_range(1, 15));
        @(negedge clk);
        s_tvalid = 1'b1;
        s_tuser = it.mode;
        s_tdata = {6'd0, it.rx_byte, it.write_byte, it.buf_index, it.count, it.slave_addr};
        do
            @(posedge clk);
        while (!s_tready);
        access_results.push_back(advance_sequencer(it));
        if (it.mode == MODE_LOAD)
            slot_loaded[it.buf_index] = 1'b1;
        items_sent++;
    endtask

    // sender pauses until the block has delivered every pending result
    task automatic wait_for_drain();
        source_gap(1);
        while (access_results.size() != 0)
            @(posedge clk);
    endtask

    function automatic item_t random_item(input logic [1:0] mode);
        item_t it;
        it.mode = mode;
        it.slave_addr = 7'($urandom);
        it.count = 6'($urandom);
        it.buf_index = 5'($urandom);
        it.write_byte = 8'($urandom);
        it.rx_byte = 8'($urandom);
        return it;
    endfunction

    task automatic load_slot(input int slot, input logic [7:0] value);
        item_t it;
        it = random_item(MODE_LOAD);
        it.buf_index = 5'(slot);
        it.write_byte = value;
        send_item(it);
    endtask

    task automatic byte_done(input logic [7:0] rx);
        item_t it;
        it = random_item(MODE_BYTE_DONE);
        it.rx_byte = rx;
        send_item(it);
    endtask

    task automatic start_access(input logic [1:0] mode, input logic [6:0] addr,
                                input logic [5:0] cnt);
        item_t it;
        it = random_item(mode);
        it.slave_addr = addr;
        it.count = cnt;
        send_item(it);
    endtask

    // number of slots loaded contiguously from slot 0
    function automatic int loaded_prefix();
        int n;
        n = 0;
        while (n < BUF_DEPTH && slot_loaded[n])
            n++;
        return n;
    endfunction

    // mostly short accesses, now and then a long one
    function automatic int pick_length();
        int r;
        r = $urandom_range(0, 19);
        if (r < 14)
            return $urandom_range(0, 4);
        else if (r < 18)
            return $urandom_range(5, 12);
        return $urandom_range(13, BUF_DEPTH);
    endfunction

    // byte-done transactions until the access closes, with stray loads and
    // starts mixed in while busy
    task automatic drive_to_idle();
        while (seq_phase != PH_IDLE)
        begin
            if ($urandom_range(0, 9) == 0)
                send_item(random_item(2'($urandom_range(0, 2))));
            else
                byte_done(8'($urandom));
        end
    endtask

    task automatic write_access(input int n);
        item_t it;
        int i;
        drive_to_idle();
        for (i = 0; i < n; i++)
        begin
            if (!slot_loaded[i] || $urandom_range(0, 2) == 0)
                load_slot(i, 8'($urandom));
        end
        it = random_item(MODE_START_WR);
        it.count = 6'(n);
        // counts past the depth saturate; only safe once every slot is loaded
        if (n == BUF_DEPTH && $urandom_range(0, 1) == 1)
            it.count = 6'($urandom_range(BUF_DEPTH, 63));
        send_item(it);
        drive_to_idle();
    endtask

    task automatic read_access(input int n);
        item_t it;
        drive_to_idle();
        it = random_item(MODE_START_RD);
        it.count = 6'(n);
        if ($urandom_range(0, 19) == 0)
            it.count = 6'($urandom_range(BUF_DEPTH + 1, 63));
        send_item(it);
        drive_to_idle();
    endtask

    // any mode with random content; a write start that would open keeps to
    // the loaded prefix
    task automatic stray_item();
        item_t it;
        int p;
        it = random_item(2'($urandom_range(0, 3)));
        p = loaded_prefix();
        if (it.mode == MODE_START_WR && seq_phase == PH_IDLE)
            it.count = 6'((p == BUF_DEPTH) ? $urandom_range(0, 63) : $urandom_range(0, p));
        send_item(it);
    endtask

    task automatic test_idle_byte_done();
        byte_done(8'hFF);
        byte_done(8'h00);
    endtask

    task automatic test_write_access();
        load_slot(0, 8'h00);
        load_slot(1, 8'hFF);
        load_slot(31, 8'h5A);
        start_access(MODE_START_WR, 7'h7F, 6'd2);
        byte_done(8'h00);
        byte_done(8'hFF);
        byte_done(8'h33);
    endtask

    task automatic test_zero_length();
        start_access(MODE_START_WR, 7'h00, 6'd0);
        byte_done(8'hA5);
        start_access(MODE_START_RD, 7'h00, 6'd0);
        byte_done(8'h5A);
    endtask

    task automatic test_read_access();
        start_access(MODE_START_RD, 7'h7F, 6'd2);
        byte_done(8'h12);
        byte_done(8'h00);
        byte_done(8'hFF);
    endtask

    // start while busy is dropped, a load while busy still lands
    task automatic test_busy_rules();
        start_access(MODE_START_RD, 7'h05, 6'd1);
        start_access(MODE_START_WR, 7'h2A, 6'd0);
        load_slot(2, 8'h3C);
        byte_done(8'hC3);
        byte_done(8'h81);
    endtask

    // fill the whole store, then counts above the depth on both directions
    task automatic test_count_saturation();
        int i;
        for (i = 0; i < BUF_DEPTH; i++)
            load_slot(i, 8'($urandom));
        start_access(MODE_START_WR, 7'($urandom), 6'd63);
        drive_to_idle();
        start_access(MODE_START_RD, 7'($urandom), 6'd40);
        drive_to_idle();
    endtask

    task automatic test_random_traffic(input int target);
        int r;
        while (items_sent < target)
        begin
            r = $urandom_range(0, 9);
            if (r < 4)
                write_access(pick_length());
            else if (r < 7)
                read_access(pick_length());
            else
                stray_item();
        end
    endtask

    // receiver holds off long enough that the block backs up into s_tready
    task automatic test_receiver_backpressure();
        src_gaps_on = 1'b0;
        sink_hold_cycles = 120;
        write_access($urandom_range(4, 10));
        read_access($urandom_range(4, 10));
        write_access($urandom_range(1, 6));
        src_gaps_on = 1'b1;
    endtask

    task automatic test_drain_pause();
        wait_for_drain();
        read_access(pick_length());
        write_access(pick_length());
    endtask

    initial
    begin
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = MODE_LOAD;
        seq_phase = PH_IDLE;
        tx_left = '0;
        rx_left = '0;
        tx_ptr = '0;
        rx_ptr = '0;
        slot_loaded = '0;
        items_sent = 0;
        mismatches = 0;
        cycle_count = 0;
        sink_hold_cycles = 0;
        sink_stall_left = 0;
        src_gaps_on = 1'b1;
        sink_gaps_on = 1'b1;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed part
        test_idle_byte_done();
        test_write_access();
        test_zero_length();
        test_read_access();
        test_busy_rules();
        test_count_saturation();

        // random part with idling on both sides
        test_random_traffic(900);
        test_receiver_backpressure();
        test_drain_pause();

        // last stretch runs at full rate
        src_gaps_on = 1'b0;
        sink_gaps_on = 1'b0;
        test_random_traffic(1550);

        wait_for_drain();
        repeat (10) @(posedge clk);
        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
